// ----- hw/rtl/tdcq_pkg.sv -----
// shared types and codes for the tagged delay callback queue
package tdcq_pkg;

  localparam int TagW    = 32;
  localparam int DelayW  = 16;
  localparam int HandleW = 16;
  localparam int KindW   = 2;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_RUN     = 1'b1;

  localparam logic [KindW-1:0] KIND_ENQ_OK = 2'd0;
  localparam logic [KindW-1:0] KIND_FIRED  = 2'd1;
  localparam logic [KindW-1:0] KIND_NONE   = 2'd2;
  localparam logic [KindW-1:0] KIND_FULL   = 2'd3;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [DelayW-1:0]  delay;
    logic [TagW-1:0]    time_tag;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

// ----- hw/rtl/tagged_delay_callback_queue.sv -----
// tagged delay callback queue top level with entry ram and scan sequencer
// An enqueue transaction appends one entry (time tag, signed delay, handle) at the
// tail and answers in the next cycle with kind 0, or kind 3 when the queue is full.
// A run transaction scans the stored entries in order through the entry ram, one
// entry per cycle on its single read port, holding while the result side stalls.
// Matching entries with a delay of zero or less fire and are removed, each
// reported as kind 1 in queue order with tlast on the final one; matching entries
// with a positive delay are decremented; the rest are compacted in place. A run
// that fires nothing answers with kind 2.
module tagged_delay_callback_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // time_tag [31:0], delay [47:32], handle [63:48]
  input  logic [0:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // fired_handle
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast
);

  import tdcq_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]          st;
  logic [CW-1:0]       fill;
  logic [CW-1:0]       ev;
  logic                dv;
  logic [CW-1:0]       wr_idx;
  logic                pend;
  logic [HandleW-1:0]  pend_handle;
  logic [TagW-1:0]     run_tag;

  logic                out_valid;
  logic [KindW-1:0]    out_kind;
  logic [HandleW-1:0]  out_handle;
  logic                out_last;

  entry_t              in_entry;
  entry_t              rd_entry;
  entry_t              wr_entry;
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [IW-1:0]       ram_raddr;
  logic [EntryW-1:0]   ram_rdata;

  logic                load_ok;
  logic                in_acc;
  logic                is_full;
  logic                match;
  logic                pos_delay;
  logic                fire;
  logic                stall;
  logic                step;
  logic                scan_last;
  logic [CW-1:0]       ev_inc;

  assign in_entry  = entry_t'(s_tdata);
  assign rd_entry  = entry_t'(ram_rdata);
  assign load_ok   = !out_valid || m_tready;
  assign s_tready  = (st == ST_IDLE) && load_ok;
  assign in_acc    = s_tvalid && s_tready;
  assign is_full   = (fill == CW'(QUEUE_DEPTH));

  assign match     = (rd_entry.time_tag == run_tag);
  assign pos_delay = !rd_entry.delay[DelayW-1] && (rd_entry.delay != '0);
  assign fire      = match && !pos_delay;
  assign stall     = fire && pend && !load_ok;
  assign step      = (st == ST_SCAN) && dv && !stall;
  assign ev_inc    = ev + CW'(1);
  assign scan_last = (ev_inc == fill);

  always_comb begin
    wr_entry = rd_entry;
    if (match && pos_delay) begin
      wr_entry.delay = rd_entry.delay - DelayW'(1);
    end
    ram_we    = 1'b0;
    ram_waddr = fill[IW-1:0];
    if (in_acc && s_tuser[0] == OP_ENQUEUE && !is_full) begin
      ram_we   = 1'b1;
      wr_entry = in_entry;
    end else if (step && !fire) begin
      ram_we    = 1'b1;
      ram_waddr = wr_idx[IW-1:0];
    end
    if (!dv) begin
      ram_raddr = '0;
    end else if (stall) begin
      ram_raddr = ev[IW-1:0];
    end else begin
      ram_raddr = ev_inc[IW-1:0];
    end
  end

  tdcq_ram #(
    .WIDTH(EntryW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_entry),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      fill      <= '0;
      ev        <= '0;
      dv        <= 1'b0;
      wr_idx    <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (in_acc) begin
            out_valid  <= 1'b1;
            out_handle <= '0;
            out_last   <= 1'b1;
            if (s_tuser[0] == OP_ENQUEUE) begin
              if (is_full) begin
                out_kind <= KIND_FULL;
              end else begin
                out_kind <= KIND_ENQ_OK;
                fill     <= fill + CW'(1);
              end
            end else if (fill == '0) begin
              out_kind <= KIND_NONE;
            end else begin
              out_valid <= 1'b0;
              st        <= ST_SCAN;
              run_tag   <= in_entry.time_tag;
              ev        <= '0;
              dv        <= 1'b0;
              wr_idx    <= '0;
              pend      <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (!dv) begin
            dv <= 1'b1;
          end else if (!stall) begin
            if (fire) begin
              if (pend) begin
                out_valid  <= 1'b1;
                out_kind   <= KIND_FIRED;
                out_handle <= pend_handle;
                out_last   <= 1'b0;
              end
              pend        <= 1'b1;
              pend_handle <= rd_entry.handle;
            end else begin
              wr_idx <= wr_idx + CW'(1);
            end
            ev <= ev_inc;
            if (scan_last) begin
              st <= ST_FINISH;
              dv <= 1'b0;
            end
          end
        end
        ST_FINISH: begin
          if (load_ok) begin
            out_valid <= 1'b1;
            out_last  <= 1'b1;
            if (pend) begin
              out_kind   <= KIND_FIRED;
              out_handle <= pend_handle;
            end else begin
              out_kind   <= KIND_NONE;
              out_handle <= '0;
            end
            fill <= wr_idx;
            pend <= 1'b0;
            st   <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_handle;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule

// ----- hw/rtl/tdcq_ram.sv -----
// generic simple dual-port ram with registered read
module tdcq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
